// File: rtl/sdaf_pkg.sv
// Shared types, constants and the double-dabble step of the signed decimal formatter.
package sdaf_pkg;

    localparam int NumW         = 32;
    localparam int ChrW         = 8;
    localparam int NumDigits    = 10;
    localparam int BcdW         = 4 * NumDigits;
    localparam int NumChars     = NumDigits + 1;
    localparam int IdxW         = 4;
    localparam int BitsPerStage = 8;
    localparam int NumStages    = NumW / BitsPerStage;

    localparam logic [IdxW-1:0] FirstIdx = '0;
    localparam logic [IdxW-1:0] LastIdx  = 4'(NumChars - 1);

    localparam logic [ChrW-1:0] ChrPlus   = 8'h2B;
    localparam logic [ChrW-1:0] ChrMinus  = 8'h2D;
    localparam logic [ChrW-1:0] ChrZero   = 8'h30;
    localparam logic [ChrW-1:0] ChrNine   = 8'h39;
    localparam logic [3:0]      ChrZeroHi = 4'h3;

    typedef logic signed [NumW-1:0] t_num;
    typedef logic [ChrW-1:0]        t_chr;
    typedef logic [BcdW-1:0]        t_bcd;

    typedef struct packed {
        logic            neg;
        logic [NumW-1:0] bin;
        t_bcd            bcd;
    } t_conv;

    // Shifts BitsPerStage binary bits into the BCD digits, correcting each digit
    // that would overflow before every shift.
    function automatic t_conv dabble_bits(input t_conv c);
        t_conv r;
        r = c;
        for (int s = 0; s < BitsPerStage; s++) begin
            for (int d = 0; d < NumDigits; d++) begin
                if (r.bcd[d*4 +: 4] >= 4'd5) begin
                    r.bcd[d*4 +: 4] = r.bcd[d*4 +: 4] + 4'd3;
                end
            end
            {r.bcd, r.bin} = {r.bcd[BcdW-2:0], r.bin, 1'b0};
        end
        return r;
    endfunction

endpackage

// File: rtl/sdaf_ifs.sv
// Valid/ready channel interfaces for the input number and the output characters.
interface sdaf_num_if;
    logic           valid;
    logic           ready;
    sdaf_pkg::t_num number;

    modport source (output valid, output number, input ready);
    modport sink   (input valid, input number, output ready);
endinterface

interface sdaf_chr_if;
    logic           valid;
    logic           ready;
    sdaf_pkg::t_chr character;
    logic           last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface

// File: rtl/signed_decimal_ascii_formatter_top.sv
// Top level of the signed decimal formatter: pipelined binary-to-BCD conversion and serializer.
//
// The block takes one signed 32-bit number per item on i_num and answers with
// eleven ASCII characters on o_chr: '+' or '-' first, then ten zero-padded
// decimal digits of the magnitude, most significant first. The last flag is set
// on the eleventh character. The most negative number prints as -2147483648.
// An accepted number passes a magnitude stage and four conversion stages, each
// of which shifts eight bits through the BCD digits, and then moves into the
// serializer, which sends its characters one after another.
// The character channel moves one character per cycle while the receiver
// keeps o_chr.ready high, and each number takes eleven characters; the
// serializer loads the next number in the same cycle that the last character
// of the previous one is taken.
// The pipeline buffers up to five numbers behind the serializer, so i_num
// stays ready for a while after the output begins to stall.
// When the receiver holds o_chr.ready low, the current character holds and the
// stall spreads back stage by stage; nothing is dropped or repeated.
// Reset (synchronous, active low) empties all stages and the serializer.
module signed_decimal_ascii_formatter_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    sdaf_num_if.sink          i_num,
    sdaf_chr_if.source        o_chr
);

    localparam int LastStage = sdaf_pkg::NumStages;

    // Stage 0 holds the magnitude; stages 1..LastStage run the conversion.
    logic                  r_vld  [0:LastStage];
    sdaf_pkg::t_conv       r_conv [0:LastStage];
    logic                  n_vld  [0:LastStage];
    sdaf_pkg::t_conv       n_conv [0:LastStage];
    logic                  stg_rdy[0:LastStage];

    // Serializer state: the sign character and the digits still to be sent.
    logic                          r_ser_vld;
    logic [sdaf_pkg::IdxW-1:0]     r_idx;
    sdaf_pkg::t_chr                r_sign;
    sdaf_pkg::t_bcd                r_digits;

    logic                  ser_last;
    logic                  ser_rdy;
    logic                  ser_load;
    logic                  out_fire;
    logic [sdaf_pkg::NumW-1:0] n_mag;

    // A stage can take new data when it is empty or its contents move on.
    always_comb begin
        stg_rdy[LastStage] = !r_vld[LastStage] || ser_rdy;
        for (int k = LastStage - 1; k >= 0; k--) begin
            stg_rdy[k] = !r_vld[k] || stg_rdy[k+1];
        end
    end

    assign i_num.ready = stg_rdy[0];

    // Two's-complement negation gives the magnitude; the most negative number
    // maps onto 2147483648 as an unsigned value, which is exactly what we want.
    assign n_mag = i_num.number[sdaf_pkg::NumW-1] ? (~i_num.number + 1'b1) : i_num.number;

    always_comb begin
        n_vld[0]       = i_num.valid;
        n_conv[0].neg  = i_num.number[sdaf_pkg::NumW-1];
        n_conv[0].bin  = n_mag;
        n_conv[0].bcd  = '0;
        for (int k = 1; k <= LastStage; k++) begin
            n_vld[k]  = r_vld[k-1];
            n_conv[k] = sdaf_pkg::dabble_bits(r_conv[k-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= LastStage; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else begin
            for (int k = 0; k <= LastStage; k++) begin
                if (stg_rdy[k]) begin
                    r_vld[k] <= n_vld[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k <= LastStage; k++) begin
            if (stg_rdy[k]) begin
                r_conv[k] <= n_conv[k];
            end
        end
    end

    // Serializer: character 0 is the sign, characters 1..10 come from the top
    // nibble of the digit register, which shifts after each digit is taken.
    assign ser_last = (r_idx == sdaf_pkg::LastIdx);
    assign out_fire = o_chr.valid && o_chr.ready;
    assign ser_rdy  = !r_ser_vld || (o_chr.ready && ser_last);
    assign ser_load = r_vld[LastStage] && ser_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ser_vld <= 1'b0;
            r_idx     <= sdaf_pkg::FirstIdx;
        end else if (ser_load) begin
            r_ser_vld <= 1'b1;
            r_idx     <= sdaf_pkg::FirstIdx;
        end else if (out_fire) begin
            if (ser_last) begin
                r_ser_vld <= 1'b0;
                r_idx     <= sdaf_pkg::FirstIdx;
            end else begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ser_load) begin
            r_sign   <= r_conv[LastStage].neg ? sdaf_pkg::ChrMinus : sdaf_pkg::ChrPlus;
            r_digits <= r_conv[LastStage].bcd;
        end else if (out_fire && (r_idx != sdaf_pkg::FirstIdx)) begin
            r_digits <= {r_digits[sdaf_pkg::BcdW-5:0], 4'h0};
        end
    end

    assign o_chr.valid     = r_ser_vld;
    assign o_chr.last      = ser_last;
    assign o_chr.character = (r_idx == sdaf_pkg::FirstIdx) ? r_sign :
                             {sdaf_pkg::ChrZeroHi, r_digits[sdaf_pkg::BcdW-1 -: 4]};

    // The character index only moves while the serializer holds an item.
    a_idx_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_ser_vld |-> (r_idx == sdaf_pkg::FirstIdx))
        else $error("serializer index not at start while empty");

    // A stalled final conversion stage keeps its item.
    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[LastStage] && !ser_rdy) |=> (r_vld[LastStage] && $stable(r_conv[LastStage])))
        else $error("final conversion stage changed during a stall");

    // The first character of an item is a sign.
    a_sign_chr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_chr.valid && (r_idx == sdaf_pkg::FirstIdx)) |->
        ((o_chr.character == sdaf_pkg::ChrPlus) || (o_chr.character == sdaf_pkg::ChrMinus)))
        else $error("first character is not a sign");

    // Every later character is a decimal digit, so the conversion left no bad BCD.
    a_digit_chr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_chr.valid && (r_idx != sdaf_pkg::FirstIdx)) |->
        ((o_chr.character >= sdaf_pkg::ChrZero) && (o_chr.character <= sdaf_pkg::ChrNine)))
        else $error("digit character out of range");

endmodule
